>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("never");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

>>> hw/rtl/fpalu_pkg.sv
// shared types, opcodes and constants of the float alu
`timescale 1ns / 1ps
`default_nettype none
package fpalu_pkg;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [30:0] EXP_INF   = 31'h7F80_0000;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_REM = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        K_ADD, K_MUL, K_DIV, K_REM, K_CONST
    } kind_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        kind_t       kind;
        logic [31:0] const_val;
        logic        bad;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PREP, ST_LOOP, ST_NORM, ST_ROUND, ST_DONE
    } state_t;
endpackage
`default_nettype wire

>>> hw/rtl/float_four_op_remainder_alu.sv
// top level of the single-precision add, subtract, multiply, divide and remainder unit
`timescale 1ns / 1ps
`default_nettype none
// A request on s_ is decoded by the front end, which resolves zero, infinite
// and NaN operands and registers the command, and then waits in a two-entry
// queue for the sequential back end, which works on one request at a time.
// In the back end, requests settled by the front end go straight to done;
// add, subtract and multiply normalize by one shift per step before rounding;
// divide makes one quotient bit per cycle; remainder does one subtract and
// shift step per bit of exponent difference. The back end is ready for its
// next request in the cycle after its result is taken.
// NaN results are 0x7FC00000 with m_nan_flag set; opcodes 5 to 7 add and set
// m_invalid_op.
module float_four_op_remainder_alu #(
    parameter int unsigned QDEPTH = fpalu_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_operand_a,
    input  wire logic [31:0] s_operand_b,
    input  wire logic [2:0]  s_opcode,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_result_bits,
    output logic             m_nan_flag,
    output logic             m_invalid_op
);
    import fpalu_pkg::*;

    logic f_valid, f_ready, b_valid, b_ready;
    cmd_t f_cmd, b_cmd;

    fpalu_front u_front (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready),
        .a(s_operand_a), .b(s_operand_b), .op(s_opcode),
        .q_valid(f_valid), .q_ready(f_ready), .q_cmd(f_cmd)
    );

    fpalu_queue #(.DEPTH(QDEPTH)) u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
    );

    fpalu_back u_back (
        .aclk, .aresetn,
        .q_valid(b_valid), .q_ready(b_ready), .q_cmd(b_cmd),
        .m_valid, .m_ready, .m_result_bits, .m_nan_flag, .m_invalid_op
    );
endmodule
`default_nettype wire

>>> hw/rtl/fpalu_front.sv
// front end: decodes opcode and resolves special operand cases
`timescale 1ns / 1ps
`default_nettype none
module fpalu_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [31:0]       a,
    input  wire logic [31:0]       b,
    input  wire logic [2:0]        op,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output fpalu_pkg::cmd_t        q_cmd
);
    import fpalu_pkg::*;

    cmd_t cmd_next;
    logic valid_reg;
    cmd_t cmd_reg;

    logic [30:0] ua, ub;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [31:0] bx;
    logic        sa, sb;

    always_comb begin
        ua = a[30:0];
        ub = b[30:0];
        a_nan = ua > EXP_INF;
        b_nan = ub > EXP_INF;
        a_inf = ua == EXP_INF;
        b_inf = ub == EXP_INF;
        a_zero = ua == 31'd0;
        b_zero = ub == 31'd0;
        bx = (op == OP_SUB) ? {~b[31], b[30:0]} : b;
        sa = a[31];
        sb = bx[31];
        cmd_next.a = a;
        cmd_next.b = bx;
        cmd_next.bad = op > OP_REM;
        cmd_next.const_val = CANON_NAN;
        cmd_next.kind = K_CONST;
        case (op)
            OP_MUL: begin
                if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
                    cmd_next.const_val = CANON_NAN;
                else if (a_inf || b_inf)
                    cmd_next.const_val = {sa ^ sb, EXP_INF};
                else if (a_zero || b_zero)
                    cmd_next.const_val = {sa ^ sb, 31'd0};
                else
                    cmd_next.kind = K_MUL;
            end
            OP_DIV: begin
                if (a_nan || b_nan || b_zero || (a_inf && b_inf))
                    cmd_next.const_val = CANON_NAN;
                else if (a_inf)
                    cmd_next.const_val = {sa ^ sb, EXP_INF};
                else if (b_inf || a_zero)
                    cmd_next.const_val = {sa ^ sb, 31'd0};
                else
                    cmd_next.kind = K_DIV;
            end
            OP_REM: begin
                if (b_zero || ua >= EXP_INF || b_nan)
                    cmd_next.const_val = CANON_NAN;
                else if (b_inf || ua < ub)
                    cmd_next.const_val = a;
                else if (ua == ub)
                    cmd_next.const_val = {sa, 31'd0};
                else
                    cmd_next.kind = K_REM;
            end
            default: begin
                if (a_nan || b_nan || (a_inf && b_inf && sa != sb))
                    cmd_next.const_val = CANON_NAN;
                else if (a_inf)
                    cmd_next.const_val = a;
                else if (b_inf)
                    cmd_next.const_val = bx;
                else if (a_zero && b_zero)
                    cmd_next.const_val = {sa & sb, 31'd0};
                else if (b_zero)
                    cmd_next.const_val = a;
                else if (a_zero)
                    cmd_next.const_val = bx;
                else
                    cmd_next.kind = K_ADD;
            end
        endcase
    end

    assign in_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_cmd = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            cmd_reg <= cmd_next;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/fpalu_queue.sv
// small request queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module fpalu_queue #(
    parameter int unsigned DEPTH = fpalu_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire fpalu_pkg::cmd_t in_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output fpalu_pkg::cmd_t    out_cmd
);
    import fpalu_pkg::*;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic push, pop;

    assign in_ready = cnt_reg != (AW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_cmd = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_cmd;
    end

    `include "assert_macros.svh"
    `ASSERT_CLK(a_q_no_overflow, aclk, aresetn, cnt_reg <= (AW+1)'(DEPTH))
    `ASSERT_CLK(a_q_count, aclk, aresetn,
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
    `ASSERT_CLK(a_q_empty_ptr, aclk, aresetn, (cnt_reg == '0) |-> (wp_reg == rp_reg))
endmodule
`default_nettype wire

>>> hw/rtl/fpalu_back.sv
// back end: sequential add, multiply, divide and remainder with rounding
`timescale 1ns / 1ps
`default_nettype none
module fpalu_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire fpalu_pkg::cmd_t q_cmd,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [31:0]        m_result_bits,
    output logic               m_nan_flag,
    output logic               m_invalid_op
);
    import fpalu_pkg::*;

    function automatic logic [4:0] lzc(input logic [23:0] v);
        logic [4:0] n;
        logic       f;
        n = 5'd24;
        f = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (v[i] && !f) begin
                n = 5'(23 - i);
                f = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] remnorm(input logic s, input logic signed [10:0] e,
                                            input logic [23:0] m);
        logic [4:0]  z;
        logic signed [10:0] room;
        logic [23:0] mm;
        z = lzc(m);
        room = e - 11'sd1;
        if (room >= 11'(z)) begin
            mm = m << z;
            return {s, 8'(e - 11'(z)), mm[22:0]};
        end
        mm = m << room[4:0];
        return {s, 8'd0, mm[22:0]};
    endfunction

    function automatic logic [31:0] rounded(input logic s, input logic signed [10:0] e,
                                            input logic [49:0] m, input logic st);
        logic [49:0] mm;
        logic [10:0] sh;
        logic        sk;
        logic [24:0] q;
        logic signed [10:0] ee;
        mm = m;
        sk = st;
        ee = e;
        if (e < 11'sd1) begin
            sh = 11'(11'sd1 - e);
            if (sh > 11'd49) begin
                sk = sk | (mm != '0);
                mm = '0;
            end else begin
                sk = sk | ((mm << (11'd50 - sh)) != '0);
                mm = mm >> sh;
            end
            ee = 11'sd1;
        end
        if (mm == '0 && !sk) return {s, 31'd0};
        q = {1'b0, mm[48:25]};
        if (mm[24] && ((mm[23:0] != '0) || sk || q[0])) q = q + 1'b1;
        if (q[24]) begin
            q = q >> 1;
            ee = ee + 1'b1;
        end
        if (!q[23]) return {s, 8'd0, q[22:0]};
        if (ee >= 11'sd255) return {s, 8'hFF, 23'd0};
        return {s, 8'(ee), q[22:0]};
    endfunction

    state_t state_reg, state_next;
    kind_t kind_reg;
    logic  sign_reg, bad_reg;
    // working exponent, signed, biased
    logic signed [10:0] e_reg;
    // leading one at bit 48 once normalized, bits 24:0 are round and sticky bits
    logic [49:0] man_reg;
    logic [31:0] ma_reg;
    logic [23:0] mb_reg;
    logic [8:0]  cnt_reg;
    logic [31:0] res_reg;
    logic        sticky_reg;

    logic [23:0] fa, fb;
    logic [7:0]  ea, eb;
    logic        a_big, add_sign, stk;
    logic [7:0]  diff;
    logic [49:0] al, bl, shb, add_man;
    logic [47:0] prod;
    logic [32:0] dsub;
    logic [31:0] rq;
    logic [4:0]  za, zb;
    logic        norm_done;

    always_comb begin
        ea = (q_cmd.a[30:23] == 8'd0) ? 8'd1 : q_cmd.a[30:23];
        eb = (q_cmd.b[30:23] == 8'd0) ? 8'd1 : q_cmd.b[30:23];
        fa = {q_cmd.a[30:23] != 8'd0, q_cmd.a[22:0]};
        fb = {q_cmd.b[30:23] != 8'd0, q_cmd.b[22:0]};
        // larger magnitude first
        a_big = q_cmd.a[30:0] >= q_cmd.b[30:0];
        diff = a_big ? ea - eb : eb - ea;
        al = {1'b0, (a_big ? fa : fb), 25'd0};
        bl = {1'b0, (a_big ? fb : fa), 25'd0};
        shb = (diff > 8'd49) ? '0 : bl >> diff;
        stk = (diff > 8'd49) ? (bl != '0) : ((shb << diff) != bl);
        // subtract when signs differ
        add_man = (q_cmd.a[31] ^ q_cmd.b[31]) ? al - shb - 50'(stk) : al + shb;
        // exact cancellation gives +0
        add_sign = (add_man == '0 && !stk) ? 1'b0 : (a_big ? q_cmd.a[31] : q_cmd.b[31]);
        prod = ma_reg[23:0] * mb_reg;
        dsub = {1'b0, ma_reg} - {9'd0, mb_reg};
        rq = dsub[32] ? ma_reg : dsub[31:0];
        za = lzc(ma_reg[23:0]);
        zb = lzc(mb_reg);
        norm_done = man_reg[48:0] == '0 || man_reg[48] || e_reg <= 11'sd1;
    end

    assign q_ready = state_reg == ST_IDLE;
    assign m_valid = state_reg == ST_DONE;
    assign m_result_bits = res_reg;
    assign m_nan_flag = res_reg == CANON_NAN;
    assign m_invalid_op = bad_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid) state_next = (q_cmd.kind == K_CONST) ? ST_DONE : ST_PREP;
            ST_PREP: state_next = ST_LOOP;
            ST_LOOP: if (cnt_reg == 9'd0) state_next = (kind_reg == K_REM) ? ST_DONE : ST_NORM;
            ST_NORM: if (norm_done) state_next = ST_ROUND;
            ST_ROUND: state_next = ST_DONE;
            ST_DONE: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: if (q_valid) begin
                kind_reg <= q_cmd.kind;
                bad_reg <= q_cmd.bad;
                res_reg <= q_cmd.const_val;
                ma_reg <= {8'd0, fa};
                mb_reg <= fb;
                sticky_reg <= (q_cmd.kind == K_ADD) && stk;
                case (q_cmd.kind)
                    K_ADD: begin
                        sign_reg <= add_sign;
                        e_reg <= 11'(a_big ? ea : eb);
                        man_reg <= add_man;
                        cnt_reg <= 9'd0;
                    end
                    K_MUL: begin
                        sign_reg <= q_cmd.a[31] ^ q_cmd.b[31];
                        e_reg <= 11'(ea) + 11'(eb) - 11'sd127;
                        man_reg <= '0;
                        cnt_reg <= 9'd0;
                    end
                    K_DIV: begin
                        sign_reg <= q_cmd.a[31] ^ q_cmd.b[31];
                        e_reg <= 11'(ea) - 11'(eb) + 11'sd127;
                        man_reg <= '0;
                        cnt_reg <= 9'd49;
                    end
                    default: begin
                        sign_reg <= q_cmd.a[31];
                        e_reg <= 11'(ea);
                        man_reg <= '0;
                        cnt_reg <= 9'(ea - eb);
                    end
                endcase
            end
            ST_PREP: begin
                case (kind_reg)
                    K_MUL: begin
                        man_reg <= {prod, 2'b00};
                    end
                    K_DIV: begin
                        // subnormal operands get their leading one at bit 23
                        ma_reg <= {8'd0, ma_reg[23:0] << za};
                        mb_reg <= mb_reg << zb;
                        e_reg <= e_reg - 11'(za) + 11'(zb);
                    end
                    default: ;
                endcase
            end
            ST_LOOP: begin
                if (cnt_reg != 9'd0) begin
                    ma_reg <= {rq[30:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (kind_reg == K_DIV) begin
                        man_reg <= {man_reg[48:0], !dsub[32]};
                    end else begin
                        e_reg <= e_reg - 1'b1;
                    end
                end else if (kind_reg == K_REM) begin
                    if (rq == '0) begin
                        res_reg <= {sign_reg, 31'd0};
                    end else if (rq[31:23] == '0) begin
                        res_reg <= remnorm(sign_reg, e_reg, rq[23:0]);
                    end else begin
                        res_reg <= {sign_reg, e_reg[7:0], rq[22:0]};
                    end
                end else if (kind_reg == K_DIV) begin
                    man_reg[0] <= man_reg[0] | (ma_reg != '0);
                end
            end
            ST_NORM: begin
                if (man_reg[49]) begin
                    man_reg <= {1'b0, man_reg[49:2], man_reg[1] | man_reg[0]};
                    e_reg <= e_reg + 1'b1;
                end else if (!norm_done) begin
                    man_reg <= {man_reg[48:0], 1'b0};
                    e_reg <= e_reg - 1'b1;
                end
            end
            ST_ROUND: begin
                res_reg <= rounded(sign_reg, e_reg, man_reg, sticky_reg);
            end
            default: ;
        endcase
    end

    `include "assert_macros.svh"
    `ASSERT_CLK(a_b_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid && $stable(res_reg))
    `ASSERT_CLK(a_b_busy, aclk, aresetn, (state_reg != ST_IDLE) |-> !q_ready)
    `ASSERT_CLK(a_b_nan, aclk, aresetn, m_valid |-> (m_nan_flag == (res_reg == CANON_NAN)))
endmodule
`default_nettype wire

>>> verif/tb_float_four_op_remainder_alu.sv
// testbench: directed and random requests checked against a float alu predictor or fixed expected results
`timescale 1ns / 1ps
module tb_float_four_op_remainder_alu;
    import fpalu_pkg::*;

    localparam logic [2:0] OP_UNDEF_5 = 3'd5;
    localparam logic [2:0] OP_UNDEF_6 = 3'd6;
    localparam logic [2:0] OP_UNDEF_7 = 3'd7;
    localparam logic [31:0] POS_INF = 32'h7F80_0000;
    localparam int N_RANDOM = 1330;

    typedef struct {
        logic [31:0] bits;
        logic        nan;
        logic        inv;
    } alu_result_t;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [2:0]  op;
        bit          typed;
        alu_result_t res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_operand_a;
    logic [31:0] s_operand_b;
    logic [2:0]  s_opcode;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_result_bits;
    logic        m_nan_flag;
    logic        m_invalid_op;

    alu_result_t pending_results[$];
    stim_row_t   directed_rows[$];
    int          mismatches = 0;
    int          hold_off_cycles = 0;
    bit          steady = 0;
    bit          next_typed = 0;
    alu_result_t next_typed_res;

    float_four_op_remainder_alu dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b), .s_opcode(s_opcode),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_bits(m_result_bits), .m_nan_flag(m_nan_flag),
        .m_invalid_op(m_invalid_op)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

    function automatic real sgl_to_real(logic [31:0] x);
        logic [10:0] ed;
        logic [22:0] f;
        logic [23:0] m;
        int          e2;
        ed = 0;
        f = x[22:0];
        if (x[30:23] == 8'hFF) begin
            return $bitstoreal({x[31], 11'h7FF, (f != 0), f[21:0], 29'd0});
        end
        if (x[30:23] == 0) begin
            if (f == 0) return $bitstoreal({x[31], 63'd0});
            m = {1'b0, f};
            e2 = -126;
            while (!m[23]) begin
                m = m << 1;
                e2--;
            end
            ed = 11'(e2 + 1023);
            return $bitstoreal({x[31], ed, m[22:0], 29'd0});
        end
        ed = 11'(int'(x[30:23]) - 127 + 1023);
        return $bitstoreal({x[31], ed, f, 29'd0});
    endfunction

    // round a double to single precision, nearest-even, subnormals included
    function automatic logic [31:0] real_to_sgl(real r);
        logic [63:0] d;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        int          es;
        int          sh;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {d[63], 31'h7F80_0000};
        if (d[62:52] == 0) return {d[63], 31'd0};
        m = {11'd0, 1'b1, d[51:0]};
        es = int'(d[62:52]) - 1023 + 127;
        sh = (es >= 1) ? 29 : 29 + 1 - es;
        if (sh >= 60) return {d[63], 31'd0};
        q = m >> sh;
        rem = m & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        if (es < 1) return {d[63], q[30:0]};
        if (q[24]) begin
            q = q >> 1;
            es++;
        end
        if (es >= 255) return {d[63], 31'h7F80_0000};
        return {d[63], 8'(es), q[22:0]};
    endfunction

    function automatic logic [31:0] fmod_bits(logic [31:0] a, logic [31:0] b);
        logic [30:0] ua;
        logic [30:0] ub;
        logic [31:0] ma;
        logic [31:0] mb;
        int          ea;
        int          eb;
        ua = a[30:0];
        ub = b[30:0];
        if (ub == 0 || ua >= EXP_INF || ub > EXP_INF) return CANON_NAN;
        if (ub == EXP_INF || ua < ub) return a;
        if (ua == ub) return {a[31], 31'd0};
        ea = ua[30:23];
        ma = {9'd0, ua[22:0]};
        if (ea == 0) ea = 1; else ma[23] = 1'b1;
        eb = ub[30:23];
        mb = {9'd0, ub[22:0]};
        if (eb == 0) eb = 1; else mb[23] = 1'b1;
        while (ea > eb) begin
            if (ma >= mb) ma = ma - mb;
            ma = ma << 1;
            ea--;
        end
        if (ma >= mb) ma = ma - mb;
        if (ma == 0) return {a[31], 31'd0};
        while (ma < 32'h0080_0000 && ea > 1) begin
            ma = ma << 1;
            ea--;
        end
        if (ma < 32'h0080_0000) return {a[31], ma[30:0]};
        return {a[31], 8'(ea), ma[22:0]};
    endfunction

    function automatic alu_result_t predict_alu(logic [31:0] a, logic [31:0] b, logic [2:0] op);
        alu_result_t res;
        real         fa;
        real         fb;
        fa = sgl_to_real(a);
        fb = sgl_to_real(b);
        res.inv = 1'b0;
        case (op)
            OP_ADD: res.bits = real_to_sgl(fa + fb);
            OP_SUB: res.bits = real_to_sgl(fa - fb);
            OP_MUL: res.bits = real_to_sgl(fa * fb);
            OP_DIV: res.bits = (b[30:0] == 0) ? CANON_NAN : real_to_sgl(fa / fb);
            OP_REM: res.bits = fmod_bits(a, b);
            default: begin
                res.bits = real_to_sgl(fa + fb);
                res.inv = 1'b1;
            end
        endcase
        res.nan = (res.bits[30:0] > EXP_INF);
        if (res.nan) res.bits = CANON_NAN;
        return res;
    endfunction

    function automatic logic [31:0] pick_operand(logic [31:0] other);
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 5))
                0: x = 32'd0;
                1: x = POS_INF;
                2: x = CANON_NAN | $urandom_range(0, 255);
                3: x = 32'h7F7F_FFFF;
                4: x = 32'h0080_0000;
                default: x = 32'h0000_0001;
            endcase
            1: x[30:23] = 8'd0;
            2, 3, 4: x[30:23] = 8'(int'(other[30:23]) + $urandom_range(0, 6) - 3);
            5: x[30:23] = 8'($urandom_range(100, 150));
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0) x[31] = $urandom;
        return x;
    endfunction

    function automatic stim_row_t mk_row(logic [31:0] a, logic [31:0] b, logic [2:0] op,
                                        bit typed, logic [31:0] r, logic nan, logic inv);
        stim_row_t row;
        row.a = a;
        row.b = b;
        row.op = op;
        row.typed = typed;
        row.res.bits = r;
        row.res.nan = nan;
        row.res.inv = inv;
        return row;
    endfunction

    task automatic send_request(logic [31:0] a, logic [31:0] b, logic [2:0] op);
        while (!steady && $urandom_range(0, 99) < 38) begin
            s_valid <= 1'b0;
            s_operand_a <= $urandom;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operand_a <= a;
        s_operand_b <= b;
        s_opcode <= op;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // predicted result is queued at the accepting edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            if (next_typed) pending_results.push_back(next_typed_res);
            else pending_results.push_back(predict_alu(s_operand_a, s_operand_b, s_opcode));
        end
    end

    always @(posedge aclk) begin
        alu_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_result_bits);
            end else begin
                want = pending_results.pop_front();
                if (m_result_bits !== want.bits || m_nan_flag !== want.nan
                    || m_invalid_op !== want.inv) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h nan %b inv %b, got %h nan %b inv %b",
                                 want.bits, want.nan, want.inv,
                                 m_result_bits, m_nan_flag, m_invalid_op);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 38);
        end
    end

    initial begin
        logic [31:0] a;
        logic [31:0] b;
        int          w;
        aresetn = 0;
        s_valid = 0;
        s_operand_a = 0;
        s_operand_b = 0;
        s_opcode = OP_ADD;
        m_ready = 0;
        directed_rows.push_back(mk_row(32'h3F80_0000, 32'h4000_0000, OP_ADD, 1,
                                       32'h4040_0000, 0, 0));
        directed_rows.push_back(mk_row(32'h4040_0000, 32'h3FC0_0000, OP_SUB, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(32'h3FC0_0000, 32'h4040_0000, OP_MUL, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(32'h3F80_0000, 32'h4040_0000, OP_DIV, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(32'h4120_0000, 32'h4040_0000, OP_REM, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(32'h7F7F_FFFF, 32'h7F7F_FFFF, OP_ADD, 1, POS_INF, 0, 0));
        directed_rows.push_back(mk_row(32'h0000_0001, 32'h0000_0001, OP_ADD, 1,
                                       32'h0000_0002, 0, 0));
        directed_rows.push_back(mk_row(32'h3F80_0000, 32'h0000_0000, OP_DIV, 1, CANON_NAN, 1, 0));
        directed_rows.push_back(mk_row(32'h3F80_0000, 32'h8000_0000, OP_DIV, 1, CANON_NAN, 1, 0));
        directed_rows.push_back(mk_row(32'h4040_0000, 32'h0000_0000, OP_REM, 1, CANON_NAN, 1, 0));
        directed_rows.push_back(mk_row(POS_INF, 32'h4040_0000, OP_REM, 1, CANON_NAN, 1, 0));
        directed_rows.push_back(mk_row(32'h4040_0000, 32'hFFC0_1234, OP_REM, 1, CANON_NAN, 1, 0));
        directed_rows.push_back(mk_row(32'hC040_0000, POS_INF, OP_REM, 1, 32'hC040_0000, 0, 0));
        directed_rows.push_back(mk_row(32'h3FC0_0000, 32'h4040_0000, OP_REM, 1,
                                       32'h3FC0_0000, 0, 0));
        directed_rows.push_back(mk_row(32'hC040_0000, 32'h3FC0_0000, OP_REM, 1,
                                       32'h8000_0000, 0, 0));
        directed_rows.push_back(mk_row(32'h7F7F_FFFF, 32'h0000_0001, OP_REM, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(32'h7FA0_0001, 32'h3F80_0000, OP_ADD, 1, CANON_NAN, 1, 0));
        directed_rows.push_back(mk_row(POS_INF, POS_INF, OP_SUB, 1, CANON_NAN, 1, 0));
        directed_rows.push_back(mk_row(32'h0000_0000, POS_INF, OP_MUL, 1, CANON_NAN, 1, 0));
        directed_rows.push_back(mk_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, OP_MUL, 1, CANON_NAN, 1, 0));
        directed_rows.push_back(mk_row(32'h3F80_0000, 32'h3F80_0000, OP_UNDEF_5, 1,
                                       32'h4000_0000, 0, 1));
        directed_rows.push_back(mk_row(32'h3F80_0000, 32'h3F80_0000, OP_UNDEF_6, 1,
                                       32'h4000_0000, 0, 1));
        directed_rows.push_back(mk_row(32'h3F80_0000, 32'h3F80_0000, OP_UNDEF_7, 1,
                                       32'h4000_0000, 0, 1));
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        foreach (directed_rows[i]) begin
            next_typed = directed_rows[i].typed;
            next_typed_res = directed_rows[i].res;
            send_request(directed_rows[i].a, directed_rows[i].b, directed_rows[i].op);
        end
        next_typed = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) hold_off_cycles = 3000;
            if (n == 600) steady = 1;
            if (n == 800) steady = 0;
            a = pick_operand($urandom);
            b = pick_operand(a);
            send_request(a, b, 3'($urandom_range(0, 7)));
        end
        s_valid <= 1'b0;
        w = 0;
        while (pending_results.size() != 0 && w < 200000) begin
            @(posedge aclk);
            w++;
        end
        repeat (400) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/fpalu_pkg.sv
hw/rtl/fpalu_front.sv
hw/rtl/fpalu_queue.sv
hw/rtl/fpalu_back.sv
hw/rtl/float_four_op_remainder_alu.sv
verif/tb_float_four_op_remainder_alu.sv
